// File: rtl/merge_sorter_macros.svh
// Assertion macros for the merge sorter. Each check samples on the rising
// edge of clk and is held off while rst_n is low.
`ifndef MERGE_SORTER_MACROS_SVH
`define MERGE_SORTER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define MS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("merge_sorter: same-cycle check failed");

// Next-cycle implication.
`define MS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("merge_sorter: next-cycle check failed");

`else

`define MS_ASSERT_IMP(lbl, ante, cons)
`define MS_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// File: rtl/ms_pkg.sv
`default_nettype none

package ms_pkg;

    localparam int DATA_W = 32;

    typedef enum logic [2:0] {
        S_LOAD,
        S_PASS,
        S_RUN_INIT,
        S_RUN_FETCH,
        S_MERGE,
        S_OUT_INIT,
        S_OUT
    } ms_state_t;

    // Commands from the controller to the datapath, at most one per cycle.
    typedef struct packed {
        logic store;
        logic run_init;
        logic run_fetch;
        logic merge;
        logic out_init;
        logic out_step;
    } ms_cmd_t;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic run_end;
        logic pass_end;
        logic sort_done;
        logic out_end;
    } ms_status_t;

endpackage

`default_nettype wire

// File: rtl/ms_ram.sv
`default_nettype none

module ms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_a,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_a <= mem_reg[raddr_a];
        rdata_b <= mem_reg[raddr_b];
    end

endmodule

`default_nettype wire

// File: rtl/ms_datapath.sv
`default_nettype none

module ms_datapath #(
    parameter int MAX_ITEMS = 64
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire ms_pkg::ms_cmd_t                     cmd,
    output ms_pkg::ms_status_t                       status,
    input  wire logic signed [ms_pkg::DATA_W-1:0]    value,
    output logic                                     result_valid,
    input  wire logic                                result_stall,
    output logic signed [ms_pkg::DATA_W-1:0]         sorted_value,
    output logic                                     last_result,
    output logic                                     overflow
);

    import ms_pkg::*;

    localparam int AW    = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int DEPTH = 1 << AW;
    localparam int CW    = $clog2(MAX_ITEMS + 1);
    localparam int SW    = CW + 2;

    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic [SW-1:0] width_reg, width_next;
    logic [CW-1:0] lo_reg, lo_next;
    logic [CW-1:0] mid_reg, mid_next;
    logic [CW-1:0] hi_reg, hi_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic [CW-1:0] k_reg, k_next;
    logic          src_reg, src_next;

    logic signed [DATA_W-1:0] head_l_reg, head_l_next;
    logic signed [DATA_W-1:0] head_r_reg, head_r_next;

    logic                     out_valid_reg, out_valid_next;
    logic signed [DATA_W-1:0] out_value_reg, out_value_next;
    logic                     out_last_reg, out_last_next;
    logic                     out_ovf_reg, out_ovf_next;

    logic [DATA_W-1:0] rd_a0, rd_a1, rd_b0, rd_b1;
    logic signed [DATA_W-1:0] rd_l, rd_r, merge_data;

    logic          we_a, we_b;
    logic [AW-1:0] waddr_a, waddr_b;
    logic [DATA_W-1:0] wdata_a;
    logic [SW-1:0] addr_l, addr_r;

    logic [SW-1:0] n_ext, lo_ext, lo_w, lo_2w, mid_calc, hi_calc;
    logic          i_valid, j_valid, take_l, full;
    logic          k_last_merge, pass_end, sort_done, out_load, out_last;

    ms_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram_a (
        .clk     (clk),
        .we      (we_a),
        .waddr   (waddr_a),
        .wdata   (wdata_a),
        .raddr_a (addr_l[AW-1:0]),
        .raddr_b (addr_r[AW-1:0]),
        .rdata_a (rd_a0),
        .rdata_b (rd_a1)
    );

    ms_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram_b (
        .clk     (clk),
        .we      (we_b),
        .waddr   (waddr_b),
        .wdata   (merge_data),
        .raddr_a (addr_l[AW-1:0]),
        .raddr_b (addr_r[AW-1:0]),
        .rdata_a (rd_b0),
        .rdata_b (rd_b1)
    );

    // Run bounds and merge decision.
    always_comb
    begin
        n_ext    = SW'(count_reg);
        lo_ext   = SW'(lo_reg);
        lo_w     = lo_ext + width_reg;
        lo_2w    = lo_ext + (width_reg << 1);
        mid_calc = (lo_w > n_ext) ? n_ext : lo_w;
        hi_calc  = (lo_2w > n_ext) ? n_ext : lo_2w;

        rd_l = src_reg ? signed'(rd_b0) : signed'(rd_a0);
        rd_r = src_reg ? signed'(rd_b1) : signed'(rd_a1);

        i_valid    = i_reg < mid_reg;
        j_valid    = j_reg < hi_reg;
        take_l     = i_valid && (!j_valid || (head_l_reg <= head_r_reg));
        merge_data = take_l ? head_l_reg : head_r_reg;
        full       = count_reg == CW'(MAX_ITEMS);

        k_last_merge = (SW'(k_reg) + SW'(1)) == SW'(hi_reg);
        pass_end     = lo_2w >= n_ext;
        sort_done    = width_reg >= n_ext;
        out_load     = !out_valid_reg || !result_stall;
        out_last     = (SW'(k_reg) + SW'(1)) == n_ext;

        status.run_end   = k_last_merge;
        status.pass_end  = pass_end;
        status.sort_done = sort_done;
        status.out_end   = cmd.out_step && out_load && out_last;
    end

    // Memory write ports. Loading fills the first store; passes ping-pong.
    always_comb
    begin
        we_a    = (cmd.store && !full) || (cmd.merge && src_reg);
        waddr_a = cmd.store ? count_reg[AW-1:0] : k_reg[AW-1:0];
        wdata_a = cmd.store ? value : merge_data;
        we_b    = cmd.merge && !src_reg;
        waddr_b = k_reg[AW-1:0];
    end

    always_comb
    begin
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        width_next     = width_reg;
        lo_next        = lo_reg;
        mid_next       = mid_reg;
        hi_next        = hi_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        src_next       = src_reg;
        head_l_next    = head_l_reg;
        head_r_next    = head_r_reg;
        out_value_next = out_value_reg;
        out_last_next  = out_last_reg;
        out_ovf_next   = out_ovf_reg;
        out_valid_next = result_stall ? out_valid_reg : 1'b0;
        addr_l         = SW'(i_reg) + SW'(1);
        addr_r         = SW'(j_reg) + SW'(1);

        if (cmd.store)
        begin
            if (full)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + CW'(1);
            end
        end

        if (cmd.run_init)
        begin
            i_next   = lo_reg;
            j_next   = mid_calc[CW-1:0];
            k_next   = lo_reg;
            mid_next = mid_calc[CW-1:0];
            hi_next  = hi_calc[CW-1:0];
            addr_l   = lo_ext;
            addr_r   = mid_calc;
        end

        if (cmd.run_fetch)
        begin
            head_l_next = rd_l;
            head_r_next = rd_r;
        end

        if (cmd.merge)
        begin
            k_next = k_reg + CW'(1);
            if (take_l)
            begin
                i_next      = i_reg + CW'(1);
                head_l_next = rd_l;
                addr_l      = SW'(i_reg) + SW'(2);
            end
            else
            begin
                j_next      = j_reg + CW'(1);
                head_r_next = rd_r;
                addr_r      = SW'(j_reg) + SW'(2);
            end
            if (k_last_merge)
            begin
                if (pass_end)
                begin
                    lo_next    = '0;
                    width_next = width_reg << 1;
                    src_next   = !src_reg;
                end
                else
                begin
                    lo_next = lo_2w[CW-1:0];
                end
            end
        end

        if (cmd.out_init)
        begin
            k_next = '0;
            addr_l = '0;
        end

        if (cmd.out_step)
        begin
            addr_l = SW'(k_reg);
            if (out_load)
            begin
                out_valid_next = 1'b1;
                out_value_next = rd_l;
                out_last_next  = out_last;
                out_ovf_next   = ovf_reg;
                k_next         = k_reg + CW'(1);
                addr_l         = SW'(k_reg) + SW'(1);
                if (out_last)
                begin
                    count_next = '0;
                    ovf_next   = 1'b0;
                    width_next = SW'(1);
                    lo_next    = '0;
                    src_next   = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            width_reg     <= SW'(1);
            lo_reg        <= '0;
            src_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            width_reg     <= width_next;
            lo_reg        <= lo_next;
            src_reg       <= src_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mid_reg       <= mid_next;
        hi_reg        <= hi_next;
        i_reg         <= i_next;
        j_reg         <= j_next;
        k_reg         <= k_next;
        head_l_reg    <= head_l_next;
        head_r_reg    <= head_r_next;
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
        out_ovf_reg   <= out_ovf_next;
    end

    assign result_valid = out_valid_reg;
    assign sorted_value = out_value_reg;
    assign last_result  = out_last_reg;
    assign overflow     = out_ovf_reg;

endmodule

`default_nettype wire

// File: rtl/ms_ctrl.sv
`default_nettype none

module ms_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    input  wire logic               last_item,
    output logic                    item_stall,
    input  wire ms_pkg::ms_status_t status,
    output ms_pkg::ms_cmd_t         cmd
);

    import ms_pkg::*;

    ms_state_t state_reg, state_next;
    logic      accept;

    assign accept = item_valid && (state_reg == S_LOAD);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_LOAD:
            begin
                if (accept && last_item)
                begin
                    state_next = S_PASS;
                end
            end
            S_PASS:
            begin
                state_next = status.sort_done ? S_OUT_INIT : S_RUN_INIT;
            end
            S_RUN_INIT:  state_next = S_RUN_FETCH;
            S_RUN_FETCH: state_next = S_MERGE;
            S_MERGE:
            begin
                if (status.run_end)
                begin
                    state_next = status.pass_end ? S_PASS : S_RUN_INIT;
                end
            end
            S_OUT_INIT:  state_next = S_OUT;
            S_OUT:
            begin
                if (status.out_end)
                begin
                    state_next = S_LOAD;
                end
            end
            default:     state_next = S_LOAD;
        endcase
    end

    always_comb
    begin
        item_stall = 1'b1;
        cmd        = '0;
        unique case (state_reg)
            S_LOAD:
            begin
                item_stall = 1'b0;
                cmd.store  = accept;
            end
            S_RUN_INIT:  cmd.run_init  = 1'b1;
            S_RUN_FETCH: cmd.run_fetch = 1'b1;
            S_MERGE:     cmd.merge     = 1'b1;
            S_OUT_INIT:  cmd.out_init  = 1'b1;
            S_OUT:       cmd.out_step  = 1'b1;
            default:     cmd           = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/merge_sorter.sv
// merge_sorter: stable ascending sort of a set of signed 32-bit values.
//
// Input channel (item_valid / item_stall, fields value and last_item): one
// value per transaction, one transaction per cycle while loading. The
// transaction with last_item set closes the set. Up to MAX_ITEMS values are
// kept; further values are dropped and flag the whole set with overflow.
// Output channel (result_valid / result_stall): one sorted value per
// transaction, ascending, equal values in arrival order; last_result marks
// the final one. Once the set closes, item_stall stays high until the final
// result sits in the output register; the next set then loads while it
// waits to be taken.
// For n stored values the sorter runs ceil(log2 n) merge passes; in each
// pass every run has its bounds set and its heads fetched and is then
// merged. Output setup follows, then the n results are unloaded in order.
// Throughput is bounded by the single merge unit, which moves one value per
// cycle between two ping-pong RAMs.
// A stalled result holds in the output register; unloading pauses with it.
// Reset empties the set, clears the overflow flag and drops any pending
// result. RAM contents are not cleared; only values of the current set are
// ever read.
`default_nettype none

`include "merge_sorter_macros.svh"

module merge_sorter #(
    parameter int MAX_ITEMS = 64
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              item_valid,
    output logic                                   item_stall,
    input  wire logic signed [ms_pkg::DATA_W-1:0]  value,
    input  wire logic                              last_item,
    output logic                                   result_valid,
    input  wire logic                              result_stall,
    output logic signed [ms_pkg::DATA_W-1:0]       sorted_value,
    output logic                                   last_result,
    output logic                                   overflow
);

    import ms_pkg::*;

    ms_cmd_t    cmd;
    ms_status_t status;

    // Sequencer: load, merge passes, unload.
    ms_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .last_item  (last_item),
        .item_stall (item_stall),
        .status     (status),
        .cmd        (cmd)
    );

    // Storage, run pointers, comparator and output register.
    ms_datapath #(.MAX_ITEMS(MAX_ITEMS)) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .value        (value),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .sorted_value (sorted_value),
        .last_result  (last_result),
        .overflow     (overflow)
    );

    // Never take a new transaction while the RAMs are being merged or read out.
    `MS_ASSERT_IMP(a_busy_stalls, cmd.run_init || cmd.merge || cmd.out_step, item_stall)
    // Hand the datapath one command at a time.
    `MS_ASSERT_IMP(a_one_cmd, 1'b1, $onehot0(cmd))
    // Fetch the run heads right after the run bounds are set.
    `MS_ASSERT_NXT(a_fetch_after_init, cmd.run_init, cmd.run_fetch)
    // Reopen the input as soon as the final result is loaded.
    `MS_ASSERT_NXT(a_load_after_out, status.out_end, !item_stall && result_valid)

endmodule

`default_nettype wire
